// ===== rtl/core/afr_pkg.sv =====
// Package for the API frame receiver: status codes, framing constants and the
// result record passed from the frame decoder to the top level.
// No dependencies.
`default_nettype none

package afr_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SUM      = 2'd1,
		ST_TYPE     = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic [7:0]  START_BYTE     = 8'h7E;
	localparam logic [7:0]  SUM_GOOD       = 8'hFF;
	localparam logic [7:0]  TYPE_RESET     = 8'h81;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd4;
	localparam logic [15:0] SOURCE_RESET   = 16'hFFFF;

	localparam int POS_LEN_HI = 1;
	localparam int POS_LEN_LO = 2;
	localparam int POS_TYPE   = 3;
	localparam int POS_SRC_HI = 4;
	localparam int POS_SRC_LO = 5;
	localparam int POS_POWER  = 8;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [15:0] source;
		logic [7:0]  power;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/afr_frame_decoder.sv =====
// Frame decoder: frame state, running sum, field captures and held fields.
// Produces at most one result per stepped byte. Depends on afr_pkg.
`default_nettype none

module afr_frame_decoder #(
	parameter int BUFFER_BYTES = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      rx_byte,
	input  wire logic [7:0]      accepted_type,
	output afr_pkg::result_t     res
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);

	logic              in_frame_q;
	logic [CW-1:0]     count_q;
	logic [16:0]       total_q;
	logic [7:0]        sum_q;
	logic [7:0]        len_hi_q;
	logic [7:0]        cap_type_q;
	logic [15:0]       cap_src_q;
	logic [7:0]        cap_pwr_q;
	logic [15:0]       held_src_q;
	logic [7:0]        held_pwr_q;

	logic              in_frame_d;
	logic [CW-1:0]     count_d;
	logic [16:0]       total_d;
	logic [7:0]        sum_d;
	logic [7:0]        len_hi_d;
	logic [7:0]        cap_type_d;
	logic [15:0]       cap_src_d;
	logic [7:0]        cap_pwr_d;
	logic [15:0]       held_src_d;
	logic [7:0]        held_pwr_d;
	afr_pkg::result_t  res_d;

	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		total_d    = total_q;
		sum_d      = sum_q;
		len_hi_d   = len_hi_q;
		cap_type_d = cap_type_q;
		cap_src_d  = cap_src_q;
		cap_pwr_d  = cap_pwr_q;
		held_src_d = held_src_q;
		held_pwr_d = held_pwr_q;
		res_d      = '{valid: 1'b0, status: afr_pkg::ST_OK,
			source: held_src_q, power: held_pwr_q};
		if (step) begin
			if (!in_frame_q) begin
				if (rx_byte == afr_pkg::START_BYTE) begin
					in_frame_d = 1'b1;
					count_d    = CW'(1);
					total_d    = '0;
					sum_d      = '0;
					len_hi_d   = '0;
					cap_type_d = '0;
					cap_src_d  = '0;
					cap_pwr_d  = '0;
				end
			end else if (count_q >= CW'(BUFFER_BYTES)) begin
				in_frame_d   = 1'b0;
				count_d      = '0;
				res_d.valid  = 1'b1;
				res_d.status = afr_pkg::ST_OVERFLOW;
			end else begin
				if (count_q == CW'(afr_pkg::POS_LEN_HI)) begin
					len_hi_d = rx_byte;
				end else if (count_q == CW'(afr_pkg::POS_LEN_LO)) begin
					total_d = afr_pkg::FRAME_OVERHEAD + {1'b0, len_hi_q, rx_byte};
				end else begin
					sum_d = sum_q + rx_byte;
					if (count_q == CW'(afr_pkg::POS_TYPE))
						cap_type_d = rx_byte;
					if (count_q == CW'(afr_pkg::POS_SRC_HI))
						cap_src_d[15:8] = rx_byte;
					if (count_q == CW'(afr_pkg::POS_SRC_LO))
						cap_src_d[7:0] = rx_byte;
					if (count_q == CW'(afr_pkg::POS_POWER))
						cap_pwr_d = rx_byte;
				end
				count_d = count_q + CW'(1);
				if (count_q >= CW'(afr_pkg::POS_TYPE)
						&& (17'(count_q) + 17'd1) == total_d) begin
					in_frame_d  = 1'b0;
					count_d     = '0;
					res_d.valid = 1'b1;
					priority if (sum_d != afr_pkg::SUM_GOOD) begin
						res_d.status = afr_pkg::ST_SUM;
					end else if (cap_type_d != accepted_type) begin
						res_d.status = afr_pkg::ST_TYPE;
					end else begin
						res_d.status = afr_pkg::ST_OK;
						held_src_d   = cap_src_d;
						held_pwr_d   = cap_pwr_d;
						res_d.source = cap_src_d;
						res_d.power  = cap_pwr_d;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			total_q    <= '0;
			sum_q      <= '0;
			len_hi_q   <= '0;
			cap_type_q <= '0;
			cap_src_q  <= '0;
			cap_pwr_q  <= '0;
			held_src_q <= afr_pkg::SOURCE_RESET;
			held_pwr_q <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			total_q    <= total_d;
			sum_q      <= sum_d;
			len_hi_q   <= len_hi_d;
			cap_type_q <= cap_type_d;
			cap_src_q  <= cap_src_d;
			cap_pwr_q  <= cap_pwr_d;
			held_src_q <= held_src_d;
			held_pwr_q <= held_pwr_d;
		end
	end

	assign res = res_d;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> count_q == '0)
		else $error("count nonzero outside a frame");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (count_q >= CW'(1) && count_q <= CW'(BUFFER_BYTES)))
		else $error("frame byte count out of range");

	a_result_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> !in_frame_q)
		else $error("frame still open after result");

	a_fail_keeps_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != afr_pkg::ST_OK) |=>
			($stable(held_src_q) && $stable(held_pwr_q)))
		else $error("held fields changed by failed frame");

endmodule

`default_nettype wire

// ===== rtl/core/api_frame_receiver.sv =====
// API frame receiver top level: input register, frame decoder, result register
// and the accepted frame type register. Depends on afr_pkg, afr_frame_decoder.
//
// Usage:
//   s_tdata carries one received serial byte per item. m_tdata carries one
//   result per finished or discarded frame: a status code (ok, checksum
//   mismatch, unsupported frame type, overflow) with the held sender address
//   and power byte after any update by that frame. Bytes outside a frame
//   other than the start byte give no result.
//   cfg_we/cfg_wdata write the accepted frame type (reset 0x81); write it only
//   while no frame bytes are in flight.
//   A result appears on m_tvalid once the frame's last byte has been stepped
//   out of the input register (decode, then result register).
//   Throughput: one byte per cycle unless a result waits on a low m_tready,
//   set by the single decode step between the input and result registers.
//   Reset: no frame open, held address 0xFFFF, held power 0, both channels
//   empty.
//   Stall: when m_tready is low with a result waiting, one more byte is taken
//   if the input register is empty; s_tready then drops until the result is taken.
`default_nettype none

module api_frame_receiver #(
	parameter int BUFFER_BYTES = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [1:0] frame_status, [17:2] source_address,
	                                    // [25:18] power_level, [31:26] zero
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        accepted_type_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [15:0]       source_q;
	logic [7:0]        power_q;
	logic              advance;
	logic              step;
	afr_pkg::result_t  res;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_type_q <= afr_pkg::TYPE_RESET;
		end else if (cfg_we) begin
			accepted_type_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	afr_frame_decoder #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (byte_s1),
		.accepted_type (accepted_type_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			status_q <= res.status;
			source_q <= res.source;
			power_q  <= res.power;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, power_q, source_q, status_q};

endmodule

`default_nettype wire

// ===== bench/afr_frame_checker.sv =====
// Checker for the API frame receiver: follows the byte and result channels,
// predicts each frame result and compares it field by field.
// Depends on afr_pkg.
`timescale 1ns / 100ps

module afr_frame_checker #(
	parameter int BUFFER_BYTES = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	output int               fail_count,
	output int               pending,
	output logic             frame_open
);

	typedef struct {
		afr_pkg::status_t status;
		logic [15:0]      source;
		logic [7:0]       power;
	} frame_result_t;

	frame_result_t expected_frames[$];

	logic [7:0]  accept_type;
	int          byte_count;
	logic [16:0] total_len;
	logic [7:0]  frame_sum;
	logic [7:0]  len_hi;
	logic [7:0]  cap_type;
	logic [15:0] cap_src;
	logic [7:0]  cap_pwr;
	logic [15:0] held_src;
	logic [7:0]  held_pwr;

	initial begin
		fail_count = 0;
		pending = 0;
		frame_open = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic close_frame(input afr_pkg::status_t st);
		frame_result_t r;
		frame_open = 1'b0;
		byte_count = 0;
		if (st == afr_pkg::ST_OK) begin
			held_src = cap_src;
			held_pwr = cap_pwr;
		end
		r.status = st;
		r.source = held_src;
		r.power = held_pwr;
		expected_frames.push_back(r);
	endtask

	task automatic predict_byte(input logic [7:0] b);
		int pos;
		if (!frame_open) begin
			if (b == afr_pkg::START_BYTE) begin
				frame_open = 1'b1;
				byte_count = 1;
				total_len = '0;
				frame_sum = '0;
				len_hi = '0;
				cap_type = '0;
				cap_src = '0;
				cap_pwr = '0;
			end
			return;
		end
		pos = byte_count;
		if (pos >= BUFFER_BYTES) begin
			close_frame(afr_pkg::ST_OVERFLOW);
			return;
		end
		if (pos == afr_pkg::POS_LEN_HI) begin
			len_hi = b;
		end else if (pos == afr_pkg::POS_LEN_LO) begin
			total_len = afr_pkg::FRAME_OVERHEAD + {1'b0, len_hi, b};
		end else begin
			frame_sum = frame_sum + b;
			if (pos == afr_pkg::POS_TYPE)
				cap_type = b;
			else if (pos == afr_pkg::POS_SRC_HI)
				cap_src[15:8] = b;
			else if (pos == afr_pkg::POS_SRC_LO)
				cap_src[7:0] = b;
			else if (pos == afr_pkg::POS_POWER)
				cap_pwr = b;
		end
		byte_count = pos + 1;
		if (pos >= afr_pkg::POS_TYPE && byte_count == int'(total_len)) begin
			if (frame_sum != afr_pkg::SUM_GOOD)
				close_frame(afr_pkg::ST_SUM);
			else if (cap_type != accept_type)
				close_frame(afr_pkg::ST_TYPE);
			else
				close_frame(afr_pkg::ST_OK);
		end
	endtask

	task automatic check_result(input logic [31:0] got);
		frame_result_t want;
		if (expected_frames.size() == 0) begin
			report_mismatch("result with no frame pending", got, '0);
			return;
		end
		want = expected_frames.pop_front();
		if (got[1:0] != want.status)
			report_mismatch("frame_status", 32'(got[1:0]), 32'(want.status));
		if (got[17:2] != want.source)
			report_mismatch("source_address", 32'(got[17:2]), 32'(want.source));
		if (got[25:18] != want.power)
			report_mismatch("power_level", 32'(got[25:18]), 32'(want.power));
		if (got[31:26] != '0)
			report_mismatch("tdata padding", 32'(got[31:26]), '0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_type = afr_pkg::TYPE_RESET;
			frame_open = 1'b0;
			byte_count = 0;
			total_len = '0;
			frame_sum = '0;
			len_hi = '0;
			cap_type = '0;
			cap_src = '0;
			cap_pwr = '0;
			held_src = afr_pkg::SOURCE_RESET;
			held_pwr = '0;
			expected_frames.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				predict_byte(s_tdata);
			if (cfg_we)
				accept_type = cfg_wdata;
			pending = expected_frames.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the API frame receiver bench: clock, reset, byte stimulus, frame type
// writes and the verdict. Depends on afr_pkg, api_frame_receiver, afr_frame_checker.
`timescale 1ns / 100ps

module tb_top;

	localparam int BUFFER_BYTES = 10;
	localparam int ITEMS_PER_PHASE = 186;
	localparam int PHASES = 8;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int          fail_count;
	int          pending;
	logic        frame_open;

	int          gap_pct = 0;
	int          stall_pct = 0;
	logic [7:0]  frame_type = afr_pkg::TYPE_RESET;

	api_frame_receiver #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	afr_frame_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending),
		.frame_open(frame_open)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#5ms;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// close any open frame with filler, then drain results
	task automatic settle_block();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (frame_open) begin
			@(posedge clk);
			push_byte(8'h00);
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_type(input logic [7:0] v);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		frame_type = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
			input bit bad_sum);
		logic [7:0] data_b;
		logic [7:0] sum;
		logic [7:0] chk;
		sum = '0;
		push_byte(afr_pkg::START_BYTE);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		for (int i = 0; i < int'(len); i++) begin
			data_b = (i == 0) ? ftype : 8'($urandom_range(255));
			sum = sum + data_b;
			push_byte(data_b);
		end
		chk = afr_pkg::SUM_GOOD - sum;
		if (bad_sum)
			chk = chk + 8'($urandom_range(1, 255));
		push_byte(chk);
	endtask

	task automatic send_random_item(inout int sent);
		int pick;
		int n;
		logic [7:0] ftype;
		logic [15:0] len;
		pick = $urandom_range(99);
		ftype = ($urandom_range(3) != 0) ? frame_type : 8'($urandom_range(255));
		if (pick < 78) begin
			len = 16'($urandom_range(0, BUFFER_BYTES - 4));
			send_frame(ftype, len, pick >= 65);
			sent += int'(len) + 4;
		end else if (pick < 88) begin
			len = 16'($urandom_range(BUFFER_BYTES - 3, 65535));
			push_byte(afr_pkg::START_BYTE);
			push_byte(len[15:8]);
			push_byte(len[7:0]);
			repeat (BUFFER_BYTES - 2) push_byte(8'($urandom_range(255)));
			sent += BUFFER_BYTES + 1;
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) push_byte(8'($urandom_range(255)));
			sent += n;
		end
	endtask

	logic [7:0] directed_bytes[] = '{
		8'h00,
		8'h7E, 8'h00, 8'h00, 8'h80,
		8'h7E, 8'h00, 8'h06, 8'h81, 8'h12, 8'h34, 8'h7E, 8'h00, 8'h5A, 8'h60,
		8'h7E, 8'h00, 8'h01, 8'h80, 8'h7F,
		8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h7E, 8'h01
	};

	logic [7:0] type_choices[PHASES] = '{8'h00, 8'hFF, 8'h81, 8'h7E, 8'h00, 8'h00,
		8'h00, 8'h00};

	initial begin
		int sent;
		for (int p = 4; p < PHASES; p++)
			type_choices[p] = 8'($urandom_range(255));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);
		for (int p = 0; p < PHASES; p++) begin
			write_frame_type(type_choices[p]);
			case (p % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 69;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 69;
				end
				default: begin
					gap_pct = 17;
					stall_pct = 17;
				end
			endcase
			@(posedge clk);
			sent = 0;
			while (sent < ITEMS_PER_PHASE)
				send_random_item(sent);
		end
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
